@@ rtl/lgh_pkg.sv @@
`timescale 1ns / 1ps

package lgh_pkg;

  // Item opcodes.
  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_HOP   = 1'b1;

  // Hop axes; the fourth code is not an axis.
  localparam logic [1:0] AX_X    = 2'd0;
  localparam logic [1:0] AX_Y    = 2'd1;
  localparam logic [1:0] AX_Z    = 2'd2;
  localparam logic [1:0] AX_NONE = 2'd3;

  // Hop directions.
  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OCCUPIED  = 2'd1;
  localparam logic [1:0] ST_ATTEMPTED = 2'd2;
  localparam logic [1:0] ST_BAD       = 2'd3;

  // Configuration register indexes and widths.
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam int unsigned SIZE_W    = 6;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;

endpackage

@@ rtl/lattice_gas_hop_engine.sv @@
`timescale 1ns / 1ps

// Lattice-gas hop engine. Atoms sit on a periodic 3D lattice whose extents are set through
// the APB registers size_x, size_y and size_z (byte addresses 0, 4 and 8); a zero extent
// counts as one site and an extent beyond 2^COORD_BITS as 2^COORD_BITS. A place beat puts
// a new atom on a free site and gives it the next index; a hop beat moves a named atom one
// site along an axis if it has not yet been tried in this sweep and the wrapped neighbour
// is free. Every beat yields exactly one result beat. Site occupancy lives in a one-bit
// memory of 2^(3*COORD_BITS) entries, and each atom's position and attempt mark share a
// second memory of MAX_ATOMS entries; both have a registered read port and one write port.
// After reset the block runs a clearing pass that writes zero to every occupancy entry,
// during which no item is accepted; register writes are taken throughout. Each item makes
// read-modify-write round trips on these memories: a bad argument goes straight to its
// result, a place reads and writes the occupancy once, and a hop reads the atom, then the
// target site if the atom is untried, and a successful hop writes the occupancy twice,
// because clearing the old site and setting the new one need two writes through the single
// occupancy port. A new beat is taken only once the previous result is ready, even while
// that result still waits in the output register, so only one result is ever held back.
module lattice_gas_hop_engine
  import lgh_pkg::*;
#(
  parameter int unsigned MAX_ATOMS  = 1024,
  parameter int unsigned COORD_BITS = 5
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [PADDR_W-1:0]                   paddr,
  input  logic [PDATA_W-1:0]                   pwdata,
  output logic [PDATA_W-1:0]                   prdata,
  output logic                                 pready,
  // Input channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 opcode_i,
  input  logic [COORD_BITS-1:0]                site_x_i,
  input  logic [COORD_BITS-1:0]                site_y_i,
  input  logic [COORD_BITS-1:0]                site_z_i,
  input  logic [$clog2(MAX_ATOMS)-1:0]         atom_index_i,
  input  logic [1:0]                           hop_axis_i,
  input  logic                                 hop_direction_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           status_o,
  output logic [$clog2(MAX_ATOMS)-1:0]         result_index_o,
  output logic [COORD_BITS-1:0]                pos_x_o,
  output logic [COORD_BITS-1:0]                pos_y_o,
  output logic [COORD_BITS-1:0]                pos_z_o,
  output logic [$clog2(MAX_ATOMS+1)-1:0]       atoms_present_o,
  output logic                                 sweep_done_o
);

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned IDX_W  = $clog2(MAX_ATOMS);
  localparam int unsigned CNT_W  = $clog2(MAX_ATOMS + 1);
  localparam int unsigned SITE_W = 3 * COORD_BITS;
  localparam int unsigned SITES  = 1 << SITE_W;
  localparam int unsigned SIDE   = 1 << COORD_BITS;
  localparam int unsigned EW     = COORD_BITS + 1;
  localparam int unsigned ATOM_W = SITE_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PLACE,
    S_HOP_ATOM,
    S_HOP_OCC,
    S_HOP_MOVE,
    S_EMIT
  } state_e;

  state_e            state_q;
  logic [SITE_W-1:0] clr_q;

  // Configuration registers and the effective extents derived from them.
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [EW-1:0]     ext_x, ext_y, ext_z;

  // Global counters.
  logic             epoch_q;
  logic [CNT_W-1:0] atom_total_q;
  logic [CNT_W-1:0] attempted_q;

  // The item at work.
  logic [SITE_W-1:0] site_q;
  logic [IDX_W-1:0]  idx_q;
  logic [1:0]        axis_q;
  logic              dir_q;
  logic [SITE_W-1:0] pos_q;
  logic [SITE_W-1:0] tgt_q;
  logic              can_q;

  // Result waiting to move into the output register.
  logic [1:0]        pend_status_q;
  logic [IDX_W-1:0]  pend_idx_q;
  logic [SITE_W-1:0] pend_pos_q;
  logic              pend_done_q;

  // Memory ports.
  logic              occ_we, occ_wdata, occ_rdata;
  logic [SITE_W-1:0] occ_waddr, occ_raddr;
  logic              atom_we;
  logic [IDX_W-1:0]  atom_waddr;
  logic [ATOM_W-1:0] atom_wdata, atom_rdata;

  logic              out_free, accept;
  logic              bad_place, bad_hop;
  logic [SITE_W-1:0] in_site;

  // Hop target decode from the atom memory read.
  logic              rd_mark;
  logic [SITE_W-1:0] rd_pos;
  logic [CB-1:0]     cur, nxt;
  logic [EW-1:0]     lim;
  logic              can;
  logic [SITE_W-1:0] tgt_site;

  // Hop resolution.
  logic             moved;
  logic [CNT_W-1:0] att_inc;
  logic             sweep_end;

  function automatic logic [EW-1:0] eff_ext(logic [SIZE_W-1:0] s);
    if (s == '0) begin
      return EW'(1);
    end else if (32'(s) > SIDE) begin
      return EW'(SIDE);
    end else begin
      return EW'(s);
    end
  endfunction

  assign ext_x = eff_ext(size_x_q);
  assign ext_y = eff_ext(size_y_q);
  assign ext_z = eff_ext(size_z_q);

  // APB: always ready, registers at word addresses.
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_SIZE_X: prdata = PDATA_W'(size_x_q);
      REG_SIZE_Y: prdata = PDATA_W'(size_y_q);
      REG_SIZE_Z: prdata = PDATA_W'(size_z_q);
      default:    prdata = '0;
    endcase
  end

  // A new beat may enter from idle, or in the cycle that hands the previous result over.
  assign out_free   = !out_valid_o || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_EMIT) && out_free);
  assign accept     = in_valid_i && in_ready_o;

  assign in_site   = {site_z_i, site_y_i, site_x_i};
  assign bad_place = ({1'b0, site_x_i} >= ext_x) || ({1'b0, site_y_i} >= ext_y) ||
                     ({1'b0, site_z_i} >= ext_z) || (atom_total_q == CNT_W'(MAX_ATOMS));
  assign bad_hop   = (CNT_W'(atom_index_i) >= atom_total_q) || (hop_axis_i == AX_NONE);

  // The atom word is the attempt mark above the packed site.
  assign rd_mark = atom_rdata[SITE_W];
  assign rd_pos  = atom_rdata[SITE_W-1:0];

  always_comb begin
    case (axis_q)
      AX_X: begin
        cur = rd_pos[CB-1:0];
        lim = ext_x;
      end
      AX_Y: begin
        cur = rd_pos[2*CB-1:CB];
        lim = ext_y;
      end
      default: begin
        cur = rd_pos[3*CB-1:2*CB];
        lim = ext_z;
      end
    endcase
    can = 1'b1;
    nxt = cur;
    if (dir_q == DIR_UP) begin
      if ({1'b0, cur} == lim - EW'(1)) begin
        nxt = '0;
      end else if ({1'b0, cur} + EW'(1) < lim) begin
        nxt = cur + CB'(1);
      end else begin
        // The atom lies beyond a shrunken extent and cannot climb.
        can = 1'b0;
      end
    end else begin
      if (cur == '0) begin
        nxt = CB'(lim - EW'(1));
      end else begin
        nxt = cur - CB'(1);
      end
    end
    tgt_site = rd_pos;
    case (axis_q)
      AX_X:    tgt_site[CB-1:0]      = nxt;
      AX_Y:    tgt_site[2*CB-1:CB]   = nxt;
      default: tgt_site[3*CB-1:2*CB] = nxt;
    endcase
  end

  assign moved     = can_q && !occ_rdata;
  assign att_inc   = attempted_q + CNT_W'(1);
  assign sweep_end = att_inc >= atom_total_q;

  // Memory addressing.
  assign occ_raddr  = (state_q == S_HOP_ATOM) ? tgt_site : in_site;
  assign atom_waddr = (state_q == S_PLACE) ? atom_total_q[IDX_W-1:0] : idx_q;

  always_comb begin
    occ_we     = 1'b0;
    occ_waddr  = tgt_q;
    occ_wdata  = 1'b1;
    atom_we    = 1'b0;
    atom_wdata = {epoch_q, pos_q};
    case (state_q)
      S_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        occ_wdata = 1'b0;
      end
      S_PLACE: begin
        occ_we     = !occ_rdata;
        occ_waddr  = site_q;
        atom_we    = !occ_rdata;
        atom_wdata = {~epoch_q, site_q};
      end
      S_HOP_OCC: begin
        // Vacate the old site now; the new one is claimed in the next cycle.
        occ_we     = moved;
        occ_waddr  = pos_q;
        occ_wdata  = 1'b0;
        atom_we    = 1'b1;
        atom_wdata = {epoch_q, moved ? tgt_q : pos_q};
      end
      S_HOP_MOVE: begin
        occ_we = 1'b1;
      end
      default: begin
        occ_we = 1'b0;
      end
    endcase
  end

  lgh_ram #(
    .WIDTH(1),
    .DEPTH(SITES)
  ) u_occ_ram (
    .clk_i  (clk_i),
    .we_i   (occ_we),
    .waddr_i(occ_waddr),
    .wdata_i(occ_wdata),
    .raddr_i(occ_raddr),
    .rdata_o(occ_rdata)
  );

  lgh_ram #(
    .WIDTH(ATOM_W),
    .DEPTH(MAX_ATOMS)
  ) u_atom_ram (
    .clk_i  (clk_i),
    .we_i   (atom_we),
    .waddr_i(atom_waddr),
    .wdata_i(atom_wdata),
    .raddr_i(atom_index_i),
    .rdata_o(atom_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_CLEAR;
      clr_q           <= '0;
      size_x_q        <= SIZE_RESET;
      size_y_q        <= SIZE_RESET;
      size_z_q        <= SIZE_RESET;
      epoch_q         <= 1'b0;
      atom_total_q    <= '0;
      attempted_q     <= '0;
      out_valid_o     <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SIZE_X: size_x_q <= pwdata[SIZE_W-1:0];
          REG_SIZE_Y: size_y_q <= pwdata[SIZE_W-1:0];
          REG_SIZE_Z: size_z_q <= pwdata[SIZE_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + SITE_W'(1);
          if (clr_q == {SITE_W{1'b1}}) begin
            state_q <= S_IDLE;
          end
        end
        S_PLACE: begin
          pend_done_q <= 1'b0;
          pend_pos_q  <= site_q;
          if (occ_rdata) begin
            pend_status_q <= ST_OCCUPIED;
            pend_idx_q    <= '0;
          end else begin
            pend_status_q <= ST_OK;
            pend_idx_q    <= atom_total_q[IDX_W-1:0];
            atom_total_q  <= atom_total_q + CNT_W'(1);
          end
          state_q <= S_EMIT;
        end
        S_HOP_ATOM: begin
          pos_q <= rd_pos;
          tgt_q <= tgt_site;
          can_q <= can;
          if (rd_mark == epoch_q) begin
            pend_status_q <= ST_ATTEMPTED;
            pend_idx_q    <= idx_q;
            pend_pos_q    <= rd_pos;
            pend_done_q   <= 1'b0;
            state_q       <= S_EMIT;
          end else begin
            state_q <= S_HOP_OCC;
          end
        end
        S_HOP_OCC: begin
          pend_status_q <= moved ? ST_OK : ST_OCCUPIED;
          pend_idx_q    <= idx_q;
          pend_pos_q    <= moved ? tgt_q : pos_q;
          pend_done_q   <= sweep_end;
          if (sweep_end) begin
            epoch_q     <= ~epoch_q;
            attempted_q <= '0;
          end else begin
            attempted_q <= att_inc;
          end
          state_q <= moved ? S_HOP_MOVE : S_EMIT;
        end
        S_HOP_MOVE: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_o     <= 1'b1;
            status_o        <= pend_status_q;
            result_index_o  <= pend_idx_q;
            pos_x_o         <= pend_pos_q[CB-1:0];
            pos_y_o         <= pend_pos_q[2*CB-1:CB];
            pos_z_o         <= pend_pos_q[3*CB-1:2*CB];
            atoms_present_o <= atom_total_q;
            sweep_done_o    <= pend_done_q;
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // Take a new beat; this overrides the return to idle above.
      if (accept) begin
        site_q <= in_site;
        idx_q  <= atom_index_i;
        axis_q <= hop_axis_i;
        dir_q  <= hop_direction_i;
        if ((opcode_i == OP_PLACE) ? bad_place : bad_hop) begin
          pend_status_q <= ST_BAD;
          pend_idx_q    <= '0;
          pend_pos_q    <= '0;
          pend_done_q   <= 1'b0;
          state_q       <= S_EMIT;
        end else if (opcode_i == OP_PLACE) begin
          state_q <= S_PLACE;
        end else begin
          state_q <= S_HOP_ATOM;
        end
      end
    end
  end

endmodule

@@ rtl/lgh_ram.sv @@
`timescale 1ns / 1ps

module lgh_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sim/tb_lattice_gas_hop_engine.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the lattice-gas hop engine.
//
// A behavioural copy of the engine lives in this module: an occupancy bit per lattice site, a
// site and an attempt mark per atom, the sweep epoch and the two counters. Every input beat is
// run through it the moment the engine accepts the beat, and the outcome is queued. The result
// monitor compares each result beat, field by field, with the oldest queued outcome.
//
// Because stimulus is built only after the previous beat has gone through the copy, the random
// part can aim hops at atoms that are still untried in the current sweep. Most hops are aimed
// that way, so sweeps really finish. The rest are noise: indexes beyond the atom count, the
// fourth axis code, and atoms that have already been tried.
//
// Reset is applied once, so atoms pile up over the whole run. The phases therefore go from small
// lattices, which crowd quickly and block many hops, to a final full-size lattice that is filled
// until the engine holds its maximum number of atoms. Further places are then refused.
module tb_lattice_gas_hop_engine;
  import lgh_pkg::*;

  localparam int unsigned MAX_ATOMS  = 1024;
  localparam int unsigned COORD_BITS = 5;
  localparam int unsigned SIDE       = 1 << COORD_BITS;
  localparam int unsigned SITES      = 1 << (3 * COORD_BITS);
  localparam int unsigned IDX_W      = $clog2(MAX_ATOMS);
  localparam int unsigned CNT_W      = $clog2(MAX_ATOMS + 1);
  localparam int unsigned FILL_PHASE = 6;

  typedef struct packed {
    logic                  op;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] sz;
    logic [IDX_W-1:0]      idx;
    logic [1:0]            axis;
    logic                  dir;
  } lattice_cmd_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [IDX_W-1:0]      idx;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [COORD_BITS-1:0] pz;
    logic [CNT_W-1:0]      present;
    logic                  done;
  } lattice_outcome_t;

  // A row of the directed script is either an input beat or a new set of lattice extents.
  typedef enum logic {ROW_BEAT, ROW_SIZES} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    lattice_cmd_t     cmd;
    logic [5:0]       nx;
    logic [5:0]       ny;
    logic [5:0]       nz;
    logic             typed;
    lattice_outcome_t want;
  } script_row_t;

  // Clock, reset and every input of the engine, all at known values from time zero.
  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         psel            = 1'b0;
  logic                         penable         = 1'b0;
  logic                         pwrite          = 1'b0;
  logic [PADDR_W-1:0]           paddr           = '0;
  logic [PDATA_W-1:0]           pwdata          = '0;
  logic [PDATA_W-1:0]           prdata;
  logic                         pready;
  logic                         in_valid_i      = 1'b0;
  logic                         in_ready_o;
  logic                         opcode_i        = OP_PLACE;
  logic [COORD_BITS-1:0]        site_x_i        = '0;
  logic [COORD_BITS-1:0]        site_y_i        = '0;
  logic [COORD_BITS-1:0]        site_z_i        = '0;
  logic [IDX_W-1:0]             atom_index_i    = '0;
  logic [1:0]                   hop_axis_i      = AX_X;
  logic                         hop_direction_i = DIR_UP;
  logic                         out_valid_o;
  logic                         out_ready_i     = 1'b0;
  logic [1:0]                   status_o;
  logic [IDX_W-1:0]             result_index_o;
  logic [COORD_BITS-1:0]        pos_x_o;
  logic [COORD_BITS-1:0]        pos_y_o;
  logic [COORD_BITS-1:0]        pos_z_o;
  logic [CNT_W-1:0]             atoms_present_o;
  logic                         sweep_done_o;

  // Behavioural copy of the engine state.
  bit                           occupied [SITES];
  logic [3*COORD_BITS-1:0]      atom_site [MAX_ATOMS];
  bit                           atom_mark [MAX_ATOMS];
  bit                           epoch = 1'b0;
  int unsigned                  atoms_held = 0;
  int unsigned                  tried_in_sweep = 0;
  logic [5:0]                   size_reg [3] = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
  logic [1:0]                   reg_code [3] = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z};

  lattice_outcome_t             awaited_outcomes [$];
  int unsigned                  mismatches = 0;
  int unsigned                  results_seen = 0;
  // Percentage of cycles in which either side holds back; zero gives a stretch at full rate.
  int unsigned                  idle_pct = 30;

  lattice_gas_hop_engine #(
    .MAX_ATOMS (MAX_ATOMS),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .site_x_i       (site_x_i),
    .site_y_i       (site_y_i),
    .site_z_i       (site_z_i),
    .atom_index_i   (atom_index_i),
    .hop_axis_i     (hop_axis_i),
    .hop_direction_i(hop_direction_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .result_index_o (result_index_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .atoms_present_o(atoms_present_o),
    .sweep_done_o   (sweep_done_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string what);
    mismatches++;
    // Only the first few are printed, so that a badly broken engine cannot flood the log.
    if (mismatches <= 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("result %0d, %s is %0d, should be %0d",
                              results_seen, name, got, want));
    end
  endtask

  // Extent of one axis as the engine uses it: zero counts as one site, anything beyond the
  // coordinate range counts as the full side.
  function automatic int unsigned extent_of(input int k);
    if (size_reg[k] == 0) return 1;
    if (size_reg[k] > SIDE) return SIDE;
    return size_reg[k];
  endfunction

  // Applies one accepted beat to the copy of the engine state and returns the result beat that
  // the engine must produce for it.
  function automatic lattice_outcome_t advance_lattice(input lattice_cmd_t cmd);
    lattice_outcome_t        res;
    logic [COORD_BITS-1:0]   pos [3];
    logic [COORD_BITS-1:0]   tgt [3];
    logic [3*COORD_BITS-1:0] from_site;
    logic [3*COORD_BITS-1:0] to_site;
    int unsigned             cur;
    int unsigned             lim;
    int                      ax;
    bit                      moved;

    res = '0;
    if (cmd.op == OP_PLACE) begin
      if (cmd.sx >= extent_of(0) || cmd.sy >= extent_of(1) || cmd.sz >= extent_of(2) ||
          atoms_held >= MAX_ATOMS) begin
        res.status = ST_BAD;
      end else begin
        to_site = {cmd.sz, cmd.sy, cmd.sx};
        res.px  = cmd.sx;
        res.py  = cmd.sy;
        res.pz  = cmd.sz;
        if (occupied[to_site]) begin
          res.status = ST_OCCUPIED;
        end else begin
          // A new atom joins the sweep as not yet tried.
          occupied[to_site]     = 1'b1;
          atom_site[atoms_held] = to_site;
          atom_mark[atoms_held] = ~epoch;
          res.status            = ST_OK;
          res.idx               = IDX_W'(atoms_held);
          atoms_held++;
        end
      end
    end else if (cmd.idx >= atoms_held || cmd.axis == AX_NONE) begin
      res.status = ST_BAD;
    end else begin
      from_site = atom_site[cmd.idx];
      pos[0]    = from_site[COORD_BITS-1:0];
      pos[1]    = from_site[2*COORD_BITS-1:COORD_BITS];
      pos[2]    = from_site[3*COORD_BITS-1:2*COORD_BITS];
      res.idx   = cmd.idx;
      if (atom_mark[cmd.idx] == epoch) begin
        res.status = ST_ATTEMPTED;
      end else begin
        ax    = cmd.axis;
        cur   = pos[ax];
        lim   = extent_of(ax);
        tgt   = pos;
        moved = 1'b1;
        if (cmd.dir == DIR_UP) begin
          // An atom stranded beyond a shrunken extent cannot move up at all.
          if (cur == lim - 1) tgt[ax] = '0;
          else if (cur + 1 < lim) tgt[ax] = cur + 1;
          else moved = 1'b0;
        end else begin
          tgt[ax] = (cur == 0) ? lim - 1 : cur - 1;
        end
        to_site = {tgt[2], tgt[1], tgt[0]};
        // On an axis of extent one the neighbour is the atom's own site, which is taken.
        if (moved && !occupied[to_site]) begin
          occupied[from_site]  = 1'b0;
          occupied[to_site]    = 1'b1;
          atom_site[cmd.idx]   = to_site;
          pos                  = tgt;
        end else begin
          moved = 1'b0;
        end
        atom_mark[cmd.idx] = epoch;
        tried_in_sweep++;
        if (tried_in_sweep >= atoms_held) begin
          epoch          = ~epoch;
          tried_in_sweep = 0;
          res.done       = 1'b1;
        end
        res.status = moved ? ST_OK : ST_OCCUPIED;
      end
      res.px = pos[0];
      res.py = pos[1];
      res.pz = pos[2];
    end
    res.present = CNT_W'(atoms_held);
    return res;
  endfunction

  // One APB transfer: setup cycle, access cycle, then a return to idle with psel low so that
  // back-to-back transfers never assign psel twice in the same step.
  task automatic apb_access(input bit wr, input logic [1:0] code, input logic [PDATA_W-1:0] word,
                            output logic [PDATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({code, 2'b00});
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every result is back, lets the pipeline settle, then writes the three extents
  // with junk in the unused upper bits and reads each one back.
  task automatic set_extents(input logic [5:0] nx, input logic [5:0] ny, input logic [5:0] nz);
    logic [5:0]         v [3];
    logic [PDATA_W-1:0] word;
    logic [PDATA_W-1:0] rd;

    v = '{nx, ny, nz};
    in_valid_i <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    for (int k = 0; k < 3; k++) begin
      word      = $urandom;
      word[5:0] = v[k];
      apb_access(1'b1, reg_code[k], word, rd);
      size_reg[k] = v[k];
      apb_access(1'b0, reg_code[k], '0, rd);
      if (rd !== PDATA_W'(v[k])) begin
        note_mismatch($sformatf("extent register %0d reads %0d after writing %0d", k, rd, v[k]));
      end
    end
  endtask

  // Presents one beat, perhaps after a random gap, and holds it until it is taken. The beat is
  // run through the copy of the engine at the edge that accepts it.
  task automatic send_beat(input lattice_cmd_t cmd, input bit typed, input lattice_outcome_t want);
    lattice_outcome_t predicted;

    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    opcode_i        <= cmd.op;
    site_x_i        <= cmd.sx;
    site_y_i        <= cmd.sy;
    site_z_i        <= cmd.sz;
    atom_index_i    <= cmd.idx;
    hop_axis_i      <= cmd.axis;
    hop_direction_i <= cmd.dir;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = advance_lattice(cmd);
    awaited_outcomes.push_back(typed ? want : predicted);
  endtask

  function automatic script_row_t beat_row(input logic op, input int x, input int y, input int z,
                                           input int idx, input logic [1:0] axis,
                                           input logic dir);
    script_row_t r;
    r          = '0;
    r.kind     = ROW_BEAT;
    r.cmd.op   = op;
    r.cmd.sx   = x;
    r.cmd.sy   = y;
    r.cmd.sz   = z;
    r.cmd.idx  = idx;
    r.cmd.axis = axis;
    r.cmd.dir  = dir;
    return r;
  endfunction

  // Attaches a result that can be written down by hand to a beat row.
  function automatic script_row_t known(input script_row_t r, input logic [1:0] status,
                                        input int idx, input int x, input int y, input int z,
                                        input int present, input logic done);
    r.typed        = 1'b1;
    r.want.status  = status;
    r.want.idx     = idx;
    r.want.px      = x;
    r.want.py      = y;
    r.want.pz      = z;
    r.want.present = present;
    r.want.done    = done;
    return r;
  endfunction

  function automatic script_row_t sizes_row(input logic [5:0] nx, input logic [5:0] ny,
                                            input logic [5:0] nz);
    script_row_t r;
    r      = '0;
    r.kind = ROW_SIZES;
    r.nx   = nx;
    r.ny   = ny;
    r.nz   = nz;
    return r;
  endfunction

  // Random extent: mostly small lattices so that they crowd, now and then a zero or an
  // oversized value.
  function automatic logic [5:0] pick_extent();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 6'd0;
    if (r == 1) return $urandom_range(63, SIDE + 1);
    if (r < 6) return $urandom_range(8, 1);
    return $urandom_range(SIDE, 1);
  endfunction

  // The result side stalls at random; idle_pct is shared with the sending side.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= idle_pct);
  end

  // Result monitor: every accepted result beat is matched against the oldest queued outcome.
  always @(posedge clk_i) begin : watch_results
    lattice_outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_outcomes.size() == 0) begin
        note_mismatch("result beat arrived with nothing outstanding");
      end else begin
        want = awaited_outcomes.pop_front();
        check_field("status", 16'(status_o), 16'(want.status));
        check_field("result_index", 16'(result_index_o), 16'(want.idx));
        check_field("pos_x", 16'(pos_x_o), 16'(want.px));
        check_field("pos_y", 16'(pos_y_o), 16'(want.py));
        check_field("pos_z", 16'(pos_z_o), 16'(want.pz));
        check_field("atoms_present", 16'(atoms_present_o), 16'(want.present));
        check_field("sweep_done", 16'(sweep_done_o), 16'(want.done));
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    script_row_t        script [$];
    lattice_cmd_t       cmd;
    logic [PDATA_W-1:0] rd;
    logic [5:0]         nx;
    logic [5:0]         ny;
    logic [5:0]         nz;
    int unsigned        place_pct;
    int unsigned        beats;
    int unsigned        count;
    int unsigned        pick;
    int unsigned        first;
    int unsigned        j;
    bit                 found;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The engine clears its occupancy memory after reset, but the registers answer at once.
    for (int k = 0; k < 3; k++) begin
      apb_access(1'b0, reg_code[k], '0, rd);
      if (rd !== PDATA_W'(SIZE_RESET)) begin
        note_mismatch($sformatf("extent register %0d reads %0d after reset", k, rd));
      end
    end

    // Directed script on the reset-size lattice first. A hop with no atoms is refused; two
    // atoms sit in opposite corners; the first hop that moves wraps down across x and the second
    // wraps up across z, which finishes the first sweep.
    script.push_back(known(beat_row(OP_HOP, 0, 0, 0, 0, AX_X, DIR_UP),
                           ST_BAD, 0, 0, 0, 0, 0, 1'b0));
    script.push_back(known(beat_row(OP_PLACE, 0, 0, 0, 1023, AX_NONE, DIR_DOWN),
                           ST_OK, 0, 0, 0, 0, 1, 1'b0));
    script.push_back(known(beat_row(OP_PLACE, 31, 31, 31, 0, AX_X, DIR_UP),
                           ST_OK, 1, 31, 31, 31, 2, 1'b0));
    script.push_back(known(beat_row(OP_PLACE, 0, 0, 0, 0, AX_X, DIR_UP),
                           ST_OCCUPIED, 0, 0, 0, 0, 2, 1'b0));
    script.push_back(known(beat_row(OP_HOP, 31, 31, 31, 1023, AX_Z, DIR_DOWN),
                           ST_BAD, 0, 0, 0, 0, 2, 1'b0));
    script.push_back(known(beat_row(OP_HOP, 0, 0, 0, 2, AX_X, DIR_UP),
                           ST_BAD, 0, 0, 0, 0, 2, 1'b0));
    script.push_back(known(beat_row(OP_HOP, 0, 0, 0, 0, AX_NONE, DIR_UP),
                           ST_BAD, 0, 0, 0, 0, 2, 1'b0));
    script.push_back(known(beat_row(OP_HOP, 0, 0, 0, 0, AX_X, DIR_DOWN),
                           ST_OK, 0, 31, 0, 0, 2, 1'b0));
    script.push_back(known(beat_row(OP_HOP, 0, 0, 0, 0, AX_Y, DIR_UP),
                           ST_ATTEMPTED, 0, 31, 0, 0, 2, 1'b0));
    script.push_back(known(beat_row(OP_HOP, 0, 0, 0, 1, AX_Z, DIR_UP),
                           ST_OK, 1, 31, 31, 0, 2, 1'b1));
    script.push_back(known(beat_row(OP_PLACE, 31, 31, 0, 0, AX_X, DIR_UP),
                           ST_OCCUPIED, 0, 31, 31, 0, 2, 1'b0));
    script.push_back(beat_row(OP_HOP, 0, 0, 0, 1, AX_Z, DIR_DOWN));
    script.push_back(beat_row(OP_HOP, 0, 0, 0, 0, AX_X, DIR_UP));
    // Zero and oversized extents: x and z shrink to a single site, y is the full side. Hops
    // along a one-site axis land on the atom itself, and the atom left at x = 31 cannot move up.
    script.push_back(sizes_row(6'd0, 6'd63, 6'd1));
    script.push_back(known(beat_row(OP_PLACE, 1, 0, 0, 0, AX_X, DIR_UP),
                           ST_BAD, 0, 0, 0, 0, 2, 1'b0));
    script.push_back(beat_row(OP_PLACE, 0, 5, 0, 0, AX_X, DIR_UP));
    script.push_back(beat_row(OP_HOP, 0, 0, 0, 2, AX_X, DIR_UP));
    script.push_back(beat_row(OP_HOP, 0, 0, 0, 1, AX_X, DIR_UP));
    script.push_back(beat_row(OP_HOP, 0, 0, 0, 0, AX_Z, DIR_DOWN));
    script.push_back(beat_row(OP_HOP, 0, 0, 0, 1, AX_X, DIR_DOWN));
    script.push_back(beat_row(OP_HOP, 0, 0, 0, 2, AX_Y, DIR_UP));
    script.push_back(sizes_row(6'd2, 6'd2, 6'd2));
    script.push_back(beat_row(OP_PLACE, 1, 1, 1, 0, AX_X, DIR_UP));
    script.push_back(beat_row(OP_HOP, 0, 0, 0, 3, AX_X, DIR_UP));
    script.push_back(beat_row(OP_PLACE, 2, 0, 0, 0, AX_X, DIR_UP));
    script.push_back(beat_row(OP_PLACE, 0, 0, 0, 0, AX_X, DIR_UP));

    foreach (script[i]) begin
      if (script[i].kind == ROW_SIZES) begin
        set_extents(script[i].nx, script[i].ny, script[i].nz);
      end else begin
        send_beat(script[i].cmd, script[i].typed, script[i].want);
      end
    end

    // Random phases. The last one uses the full lattice and runs until the engine is full,
    // followed by a tail in which places are refused and hops go on.
    for (int ph = 0; ph <= FILL_PHASE; ph++) begin
      place_pct = 50;
      beats     = 150;
      case (ph)
        0: begin
          nx    = 6'd4;
          ny    = 6'd4;
          nz    = 6'd4;
          beats = 250;
        end
        1: begin
          nx = 6'd0;
          ny = 6'd63;
          nz = 6'd2;
        end
        2: begin
          nx    = 6'd1;
          ny    = 6'd1;
          nz    = 6'd1;
          beats = 60;
        end
        FILL_PHASE: begin
          nx = 6'd32;
          ny = 6'd32;
          nz = 6'd32;
        end
        default: begin
          nx = pick_extent();
          ny = pick_extent();
          nz = pick_extent();
        end
      endcase
      set_extents(nx, ny, nz);
      // One phase runs with neither side holding back.
      idle_pct = (ph == 1) ? 0 : 30;
      count    = 0;
      while (count < beats) begin
        if (ph == FILL_PHASE) place_pct = (atoms_held < MAX_ATOMS) ? 85 : 40;
        cmd.op   = ($urandom_range(99) < place_pct) ? OP_PLACE : OP_HOP;
        cmd.sx   = $urandom_range(SIDE - 1);
        cmd.sy   = $urandom_range(SIDE - 1);
        cmd.sz   = $urandom_range(SIDE - 1);
        cmd.idx  = $urandom_range(MAX_ATOMS - 1);
        cmd.axis = $urandom_range(2);
        cmd.dir  = $urandom_range(1);
        pick     = $urandom_range(99);
        if (cmd.op == OP_PLACE) begin
          // Most places land inside the lattice; the rest may fall outside it.
          if (pick < 85) begin
            cmd.sx = $urandom_range(extent_of(0) - 1);
            cmd.sy = $urandom_range(extent_of(1) - 1);
            cmd.sz = $urandom_range(extent_of(2) - 1);
          end
        end else if (pick < 8) begin
          // Noise: any index, any axis code including the one that is not an axis.
          cmd.axis = $urandom_range(3);
        end else if (atoms_held != 0) begin
          // A held atom; most of the time the first untried one from a random start, so
          // that sweeps run to their end.
          first   = $urandom_range(atoms_held - 1);
          cmd.idx = first;
          if (pick >= 20) begin
            found = 1'b0;
            for (int n = 0; n < atoms_held; n++) begin
              j = (first + n) % atoms_held;
              if (!found && atom_mark[j] != epoch) begin
                cmd.idx = j;
                found   = 1'b1;
              end
            end
          end
        end
        send_beat(cmd, 1'b0, '0);
        if (ph != FILL_PHASE || atoms_held == MAX_ATOMS) count++;
      end
    end

    in_valid_i <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: the slowest correct run, clearing pass included, is well under a fifth of this.
  initial begin
    #1500000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
